>>> rtl/core/assert_macros.svh
// Assertion macros shared by the verification checkers.
// Depends on: a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication checked on every rising edge while out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  `ASSERT_CLK(lbl, (ante) |-> (cons))

`endif

>>> rtl/core/wps_pkg.sv
// Package for the pixel serializer: widths, register map, config struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned DutyW        = 8;
  localparam int unsigned RepW         = 10;
  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned IdxW         = 5;
  localparam int unsigned ProdW        = 2 * ChanW;
  localparam int unsigned AddrW        = 4;
  localparam int unsigned DataW        = 32;

  localparam logic [ChanW-1:0] BrightRst = 8'd255;
  localparam logic [DutyW-1:0] OneRst    = 8'd67;
  localparam logic [DutyW-1:0] ZeroRst   = 8'd34;
  localparam logic [RepW-1:0]  SlotsRst  = 10'd50;

  typedef enum logic [1:0] {
    REG_BRIGHT = 2'd0,
    REG_ONE    = 2'd1,
    REG_ZERO   = 2'd2,
    REG_SLOTS  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic [DutyW-1:0] one_duty;
    logic [DutyW-1:0] zero_duty;
    logic [RepW-1:0]  reset_slots;
  } wps_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/wps_ifs.sv
// Valid/ready channel interfaces: pixel input and PWM code output.
// Depends on: wps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wps_pix_if;
  logic                      valid;
  logic                      ready;
  logic [wps_pkg::ChanW-1:0] red;
  logic [wps_pkg::ChanW-1:0] green;
  logic [wps_pkg::ChanW-1:0] blue;
  logic                      last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface wps_res_if;
  logic                      valid;
  logic                      ready;
  logic [wps_pkg::DutyW-1:0] duty;
  logic [wps_pkg::RepW-1:0]  repeat_res;
  logic                      last;

  modport source (output valid, duty, repeat_res, last, input ready);
  modport sink   (input valid, duty, repeat_res, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wps_lane.sv
// One color lane: registered channel*brightness product, then /255.
// Depends on: wps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wps_lane (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [wps_pkg::ChanW-1:0] value_i,
  input  wire logic [wps_pkg::ChanW-1:0] bright_i,
  output logic      [wps_pkg::ChanW-1:0] scaled_o
);

  logic [wps_pkg::ProdW-1:0] prod_q;
  logic [wps_pkg::ProdW:0]   sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= value_i * bright_i;
    end
  end

  // floor(p/255) = (p + (p >> 8) + 1) >> 8, exact for 16-bit p up to 65534
  assign sum = {1'b0, prod_q}
             + (wps_pkg::ProdW+1)'(prod_q[wps_pkg::ProdW-1:wps_pkg::ChanW])
             + (wps_pkg::ProdW+1)'(1);
  assign scaled_o = sum[wps_pkg::ProdW-1:wps_pkg::ChanW];

endmodule

`default_nettype wire

>>> rtl/core/wps_cfg.sv
// APB-style register file: brightness, duty codes, latch reset length.
// Depends on: wps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wps_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel_i,
  input  wire logic                      penable_i,
  input  wire logic                      pwrite_i,
  input  wire logic [wps_pkg::AddrW-1:0] paddr_i,
  input  wire logic [wps_pkg::DataW-1:0] pwdata_i,
  output logic      [wps_pkg::DataW-1:0] prdata_o,
  output wps_pkg::wps_cfg_t              cfg_o
);

  wps_pkg::wps_cfg_t cfg_q, cfg_d;
  wps_pkg::reg_idx_e idx;
  logic              wr;

  assign idx = wps_pkg::reg_idx_e'(paddr_i[3:2]);
  assign wr  = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        wps_pkg::REG_BRIGHT: cfg_d.brightness  = pwdata_i[wps_pkg::ChanW-1:0];
        wps_pkg::REG_ONE:    cfg_d.one_duty    = pwdata_i[wps_pkg::DutyW-1:0];
        wps_pkg::REG_ZERO:   cfg_d.zero_duty   = pwdata_i[wps_pkg::DutyW-1:0];
        wps_pkg::REG_SLOTS:  cfg_d.reset_slots = pwdata_i[wps_pkg::RepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wps_pkg::REG_BRIGHT: prdata_o = wps_pkg::DataW'(cfg_q.brightness);
      wps_pkg::REG_ONE:    prdata_o = wps_pkg::DataW'(cfg_q.one_duty);
      wps_pkg::REG_ZERO:   prdata_o = wps_pkg::DataW'(cfg_q.zero_duty);
      wps_pkg::REG_SLOTS:  prdata_o = wps_pkg::DataW'(cfg_q.reset_slots);
      default:             prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness  <= wps_pkg::BrightRst;
      cfg_q.one_duty    <= wps_pkg::OneRst;
      cfg_q.zero_duty   <= wps_pkg::ZeroRst;
      cfg_q.reset_slots <= wps_pkg::SlotsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/wps_serializer.sv
// Merges the three lane results into a GRB word and shifts it out MSB first,
// one PWM code per cycle while the sink is ready, plus the latch reset code after a frame.
// Depends on: wps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wps_serializer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [wps_pkg::ChanW-1:0] red_i,
  input  wire logic [wps_pkg::ChanW-1:0] green_i,
  input  wire logic [wps_pkg::ChanW-1:0] blue_i,
  input  wire logic                      in_last_i,
  input  wire wps_pkg::wps_cfg_t         cfg_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [wps_pkg::DutyW-1:0] duty_o,
  output logic      [wps_pkg::RepW-1:0]  rep_o,
  output logic                           last_o
);

  localparam logic [wps_pkg::IdxW-1:0] LastData = wps_pkg::IdxW'(wps_pkg::BitsPerPixel - 1);
  localparam logic [wps_pkg::IdxW-1:0] ResetIdx = wps_pkg::IdxW'(wps_pkg::BitsPerPixel);

  logic [wps_pkg::BitsPerPixel-1:0] sh_q, sh_d;
  logic [wps_pkg::IdxW-1:0]         idx_q, idx_d;
  logic                             frm_q, frm_d;
  logic                             act_q, act_d;
  logic                             ov_q, ov_d;
  logic [wps_pkg::DutyW-1:0]        duty_q, duty_d;
  logic [wps_pkg::RepW-1:0]         rep_q, rep_d;
  logic                             lst_q, lst_d;
  logic                             slot_free, emit, is_data, fin, load;
  logic [wps_pkg::RepW-1:0]         slots_eff;

  assign slot_free  = !ov_q || out_ready_i;
  assign emit       = act_q && slot_free;
  assign is_data    = idx_q < ResetIdx;
  assign fin        = emit && ((idx_q == LastData && !frm_q) || idx_q == ResetIdx);
  assign in_ready_o = !act_q || fin;
  assign load       = in_valid_i && in_ready_o;
  // a latch reset lasts at least one period
  assign slots_eff  = (cfg_i.reset_slots == '0) ? wps_pkg::RepW'(1) : cfg_i.reset_slots;

  always_comb begin
    sh_d  = sh_q;
    idx_d = idx_q;
    frm_d = frm_q;
    act_d = act_q;
    if (load) begin
      sh_d  = {green_i, red_i, blue_i};
      idx_d = '0;
      frm_d = in_last_i;
      act_d = 1'b1;
    end else if (emit) begin
      sh_d  = {sh_q[wps_pkg::BitsPerPixel-2:0], 1'b0};
      idx_d = idx_q + wps_pkg::IdxW'(1);
      if (fin) begin
        act_d = 1'b0;
      end
    end
  end

  always_comb begin
    ov_d   = ov_q;
    duty_d = duty_q;
    rep_d  = rep_q;
    lst_d  = lst_q;
    if (emit) begin
      ov_d   = 1'b1;
      duty_d = !is_data ? '0 :
               (sh_q[wps_pkg::BitsPerPixel-1] ? cfg_i.one_duty : cfg_i.zero_duty);
      rep_d  = is_data ? wps_pkg::RepW'(1) : slots_eff;
      lst_d  = fin;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      act_q <= act_d;
      ov_q  <= ov_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    frm_q  <= frm_d;
    duty_q <= duty_d;
    rep_q  <= rep_d;
    lst_q  <= lst_d;
  end

  assign out_valid_o = ov_q;
  assign duty_o      = duty_q;
  assign rep_o       = rep_q;
  assign last_o      = lst_q;

endmodule

`default_nettype wire

>>> rtl/core/ws2812_pixel_serializer_unit.sv
// Path: first PWM code of a pixel passes the product register, then the
//   serializer's shift register and its output register.
// Codes: 24 per pixel, 25 for the last pixel of a frame; the single output
//   register emits one code per cycle while the sink is ready.
// Reset: rst_ni is asynchronous, active low; pipeline empties and registers take
//   brightness 255, one code 67, zero code 34, latch reset 50 periods.
`timescale 1ns / 1ps
`default_nettype none

// Pixel to WS2812 PWM code stream.
// Depends on: wps_pkg, wps_ifs, wps_lane, wps_cfg, wps_serializer.
module ws2812_pixel_serializer_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  wps_pix_if.sink                        pix_i,
  wps_res_if.source                      res_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [wps_pkg::AddrW-1:0] paddr,
  input  wire logic [wps_pkg::DataW-1:0] pwdata,
  output logic      [wps_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  wps_pkg::wps_cfg_t         cfg;
  logic                      pix_xfer;
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_last_q;
  logic                      ser_ready;
  logic [wps_pkg::ChanW-1:0] red_s, green_s, blue_s;

  // Register file; writes complete in the access phase, never stalled.
  assign pready = 1'b1;

  wps_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Stage 1: three lanes capture channel*brightness. The stage holds one pixel
  // and is freed as soon as the serializer takes it, so a new pixel can enter
  // while the previous one is still being shifted out.
  assign pix_i.ready = !s1_valid_q || ser_ready;
  assign pix_xfer    = pix_i.valid && pix_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_xfer) begin
      s1_valid_d = 1'b1;
    end else if (ser_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      s1_last_q <= pix_i.last_pixel;
    end
  end

  wps_lane u_lane_r (
    .clk_i    (clk_i),
    .en_i     (pix_xfer),
    .value_i  (pix_i.red),
    .bright_i (cfg.brightness),
    .scaled_o (red_s)
  );

  wps_lane u_lane_g (
    .clk_i    (clk_i),
    .en_i     (pix_xfer),
    .value_i  (pix_i.green),
    .bright_i (cfg.brightness),
    .scaled_o (green_s)
  );

  wps_lane u_lane_b (
    .clk_i    (clk_i),
    .en_i     (pix_xfer),
    .value_i  (pix_i.blue),
    .bright_i (cfg.brightness),
    .scaled_o (blue_s)
  );

  // Merge: GRB word into the shifter; the output register decouples the sink.
  wps_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (ser_ready),
    .red_i       (red_s),
    .green_i     (green_s),
    .blue_i      (blue_s),
    .in_last_i   (s1_last_q),
    .cfg_i       (cfg),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .duty_o      (res_o.duty),
    .rep_o       (res_o.repeat_res),
    .last_o      (res_o.last)
  );

endmodule

`default_nettype wire

>>> rtl/core/wps_checker.sv
// Port-level checker for the pixel serializer, bound to the top level.
// Depends on: assert_macros.svh, wps_pkg, ws2812_pixel_serializer_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wps_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      res_valid_i,
  input wire logic                      res_ready_i,
  input wire logic [wps_pkg::DutyW-1:0] res_duty_i,
  input wire logic [wps_pkg::RepW-1:0]  res_repeat_i,
  input wire logic                      res_last_i,
  input wire logic                      psel_i,
  input wire logic                      penable_i,
  input wire logic                      pwrite_i,
  input wire logic [wps_pkg::AddrW-1:0] paddr_i,
  input wire logic [wps_pkg::DataW-1:0] pwdata_i,
  input wire logic [wps_pkg::DataW-1:0] prdata_i
);

  logic cfg_wr;
  assign cfg_wr = psel_i && penable_i && pwrite_i;

  // a stalled code holds
  `ASSERT_IMPL(a_res_hold, res_valid_i && !res_ready_i,
    ##1 (res_valid_i && $stable(res_duty_i) && $stable(res_repeat_i) && $stable(res_last_i)))

  // only the latch reset lasts more than one period; it is silent and ends the item
  `ASSERT_IMPL(a_long_is_reset, res_valid_i && res_repeat_i != wps_pkg::RepW'(1),
    res_duty_i == '0 && res_last_i)

  // every code lasts at least one period
  `ASSERT_IMPL(a_rep_nonzero, res_valid_i, res_repeat_i != '0)

  // an 8-bit register reads back what was written
  `ASSERT_IMPL(a_readback,
    (cfg_wr && paddr_i[3:2] != 2'(wps_pkg::REG_SLOTS)) ##1
      (paddr_i[3:2] == $past(paddr_i[3:2])),
    prdata_i == wps_pkg::DataW'($past(pwdata_i[wps_pkg::DutyW-1:0])))

endmodule

bind ws2812_pixel_serializer_unit wps_checker u_wps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_duty_i   (res_o.duty),
  .res_repeat_i (res_o.repeat_res),
  .res_last_i   (res_o.last),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for ws2812_pixel_serializer_unit: pixel in, PWM code stream out.
// Depends on: wps_pkg, wps_ifs and the RTL under rtl/core; drives APB and both channels.
`timescale 1ns / 1ps

module tb_top;
  import wps_pkg::*;

  localparam int unsigned HalfPeriod = 6;       // 12 ns clock
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned CycleLimit = 400000;  // watchdog limit on the run
  localparam int unsigned HoldCycles = 600;     // long receiver hold-off, fills the pipe
  localparam int unsigned TailCycles = 10;      // idle margin before the final check
  localparam int unsigned RandPhases = 6;
  localparam int unsigned PixPerPhase = 50;
  localparam int unsigned MaxPrints = 40;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [RepW-1:0]  repeat_res;
    logic             last;
  } pwm_code_t;

  // Holds a copy of the register file, turns each accepted pixel into the
  // PWM codes it must produce, and matches codes leaving the block in order.
  class pwm_code_board;
    wps_cfg_t    cfg;
    pwm_code_t   codes_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      cfg.brightness  = BrightRst;
      cfg.one_duty    = OneRst;
      cfg.zero_duty   = ZeroRst;
      cfg.reset_slots = SlotsRst;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        REG_BRIGHT: cfg.brightness  = value[ChanW-1:0];
        REG_ONE:    cfg.one_duty    = value[DutyW-1:0];
        REG_ZERO:   cfg.zero_duty   = value[DutyW-1:0];
        REG_SLOTS:  cfg.reset_slots = value[RepW-1:0];
        default: ;
      endcase
    endfunction

    // floor(v * brightness / 255)
    function logic [ChanW-1:0] dim(logic [ChanW-1:0] v);
      logic [ProdW-1:0] prod;
      prod = v * cfg.brightness;
      return ChanW'(prod / 255);
    endfunction

    function int unsigned pending();
      return codes_q.size();
    endfunction

    // GRB, MSB first; latch reset code only on the frame's last pixel
    function void note_pixel(pixel_t px);
      logic [BitsPerPixel-1:0] grb;
      pwm_code_t               code;
      grb = {dim(px.green), dim(px.red), dim(px.blue)};
      for (int i = BitsPerPixel - 1; i >= 0; i--) begin
        code.duty       = grb[i] ? cfg.one_duty : cfg.zero_duty;
        code.repeat_res = RepW'(1);
        code.last       = !px.last_pixel && (i == 0);
        codes_q.push_back(code);
      end
      if (px.last_pixel) begin
        code.duty       = '0;
        // a zero length still gives one period of latch reset
        code.repeat_res = (cfg.reset_slots == '0) ? RepW'(1) : cfg.reset_slots;
        code.last       = 1'b1;
        codes_q.push_back(code);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_code(pwm_code_t got);
      pwm_code_t want;
      if (codes_q.size() == 0) begin
        report($sformatf("unexpected code duty=%0d rep=%0d last=%0d",
                         got.duty, got.repeat_res, got.last));
      end else begin
        want = codes_q.pop_front();
        if (got.duty !== want.duty)
          report($sformatf("duty got %0d want %0d", got.duty, want.duty));
        if (got.repeat_res !== want.repeat_res)
          report($sformatf("repeat_res got %0d want %0d", got.repeat_res, want.repeat_res));
        if (got.last !== want.last)
          report($sformatf("last got %0d want %0d", got.last, want.last));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  wps_pix_if pix ();
  wps_res_if res ();

  pwm_code_board board = new();

  // Sender pacing: bursts of random length, gaps between them when enabled
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b0;
  // Set by the stimulus, consumed by the receiver process
  bit          hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  ws2812_pixel_serializer_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Input transfers are noted at the edge where they happen; values read here
  // are the ones before the edge, since everything is driven nonblocking.
  always @(posedge clk_i) begin
    if (rst_ni && pix.valid && pix.ready)
      board.note_pixel('{red: pix.red, green: pix.green, blue: pix.blue,
                         last_pixel: pix.last_pixel});
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready)
      board.check_code('{duty: res.duty, repeat_res: res.repeat_res, last: res.last});
  end

  // Receiver: segments of always-ready, random, periodic and heavy stalling.
  // A requested hold-off drops ready so the block backs up into its input
  // while the sender keeps offering.
  initial begin : code_sink
    int unsigned mode;
    int unsigned span;
    res.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(3);
      span = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        case (mode)
          0: res.ready <= 1'b1;
          1: res.ready <= ($urandom_range(9) < 7);
          2: res.ready <= ((c % 4) != 3);
          default: res.ready <= ($urandom_range(3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // One APB write, then a read back of the same register
  task automatic program_reg(reg_idx_e idx, logic [DataW-1:0] field);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] value;
    logic [DataW-1:0] rd;
    mask  = (idx == REG_SLOTS) ? DataW'(10'h3FF) : DataW'(8'hFF);
    value = ($urandom() & ~mask) | (field & mask);  // junk above the field
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_reg(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== (value & mask))
      board.report($sformatf("reg %s read %0h want %0h", idx.name(), rd, value & mask));
  endtask

  task automatic program_all(logic [7:0] bright, logic [7:0] one, logic [7:0] zero,
                             logic [9:0] slots);
    program_reg(REG_BRIGHT, DataW'(bright));
    program_reg(REG_ONE,    DataW'(one));
    program_reg(REG_ZERO,   DataW'(zero));
    program_reg(REG_SLOTS,  DataW'(slots));
  endtask

  // Burst bookkeeping after each transfer; valid only drops inside a gap
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic offer_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit lp);
    pix.valid      <= 1'b1;
    pix.red        <= r;
    pix.green      <= g;
    pix.blue       <= b;
    pix.last_pixel <= lp;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    pace();
  endtask

  // Lower valid and wait until every expected code has left the block
  task automatic quiesce();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [9:0] pick_slots();
    case ($urandom_range(5))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned frame_len;

    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pix.valid      <= 1'b0;
    pix.red        <= '0;
    pix.green      <= '0;
    pix.blue       <= '0;
    pix.last_pixel <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset-value registers, full and empty pixels, a frame end
    offer_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    offer_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    offer_pixel(8'h80,  8'h01,  8'hFE,  1'b0);
    offer_pixel(8'h55,  8'hAA,  8'h0F,  1'b1);
    quiesce();

    // Brightness zero: every bit is a zero code; longest latch reset
    program_all(8'd0, 8'd255, 8'd0, 10'd1023);
    offer_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    offer_pixel(8'h12,  8'h34,  8'h56,  1'b0);
    quiesce();

    // Dimmest nonzero brightness, swapped codes, zero reset length
    program_all(8'd1, 8'd0, 8'd255, 10'd0);
    offer_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    offer_pixel(8'd254, 8'd128, 8'd1,   1'b1);
    quiesce();

    program_all(8'd128, 8'd200, 8'd10, 10'd1);
    offer_pixel(8'd255, 8'd0,   8'hAA, 1'b0);
    offer_pixel(8'd1,   8'd254, 8'h55, 1'b1);
    quiesce();

    // Random frames of random length under a new register setting per phase;
    // the first phase runs without sender gaps, the second gets the hold-off
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 2)
        program_all(8'd255, 8'd255, 8'd0, 10'd1023);
      else
        program_all(pick_chan(), pick_chan(), pick_chan(), pick_slots());
      gaps_on = (ph != 0);
      if (ph == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PixPerPhase) begin
        frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        for (int k = 0; k < frame_len; k++) begin
          offer_pixel(pick_chan(), pick_chan(), pick_chan(), k == frame_len - 1);
          sent++;
        end
      end
      quiesce();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wps_pkg.sv
rtl/core/wps_ifs.sv
rtl/core/wps_lane.sv
rtl/core/wps_cfg.sv
rtl/core/wps_serializer.sv
rtl/core/ws2812_pixel_serializer_unit.sv
rtl/core/wps_checker.sv
bench/tb_top.sv
